// ===== sv/cdll_pkg.sv =====
// Types and codes shared by the circular doubly linked list engine.
// No dependencies.
package cdll_pkg;

    typedef enum logic [3:0] {
        OP_INS_FRONT  = 4'd0,
        OP_INS_BACK   = 4'd1,
        OP_INS_AFTER  = 4'd2,
        OP_INS_BEFORE = 4'd3,
        OP_DEL_FRONT  = 4'd4,
        OP_DEL_BACK   = 4'd5,
        OP_DEL_MATCH  = 4'd6,
        OP_DEL_AFTER  = 4'd7,
        OP_DEL_BEFORE = 4'd8,
        OP_COUNT      = 4'd9,
        OP_DUMP       = 4'd10
    } op_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND   = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_NONEIGHBOR = 3'd4;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] new_value;
        logic signed [31:0] key_value;
    } request_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [4:0]         node_count;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LINK,
        S_UNLINK,
        S_DUMP,
        S_OUT
    } state_t;

endpackage

// ===== sv/circular_doubly_linked_list_engine_top.sv =====
// Circular doubly linked list engine, top level.
// Depends on cdll_pkg.
//
// Keeps a circular doubly linked list in a pool of CAPACITY nodes and runs one
// request at a time. Keyed requests walk the list from the head one node per
// cycle; a dump delivers one result per node per cycle (stalls permitting).
// Insert takes the lowest free slot; a full pool gives status pool full. The
// block is not ready while a request is in progress; a result sits in an
// output register and the next request is taken once it has gone.
module circular_doubly_linked_list_engine_top
    import cdll_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  request_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output result_t  out_data
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // node pool; entries read only when the slot is in use
    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
    logic [AW-1:0]          nxt_mem [CAPACITY];
    logic [AW-1:0]          prv_mem [CAPACITY];

    state_t                 state_reg, state_next;
    logic [CAPACITY-1:0]    used_reg, used_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          len_reg, len_next;
    op_t                    op_reg, op_next;
    logic [VALUE_WIDTH-1:0] nv_reg, nv_next, key_reg, key_next;
    logic [AW-1:0]          ptr_reg, ptr_next;     // walk position
    logic [CW-1:0]          cnt_reg, cnt_next;     // nodes visited
    logic [AW-1:0]          slot_reg, slot_next;   // free slot
    result_t                res_reg, res_next;
    logic                   ov_reg, ov_next;

    // memory write ports (a value port and four link ports, fixed roles)
    logic                   wv_en, wn_en, wp_en, wn2_en, wp2_en;
    logic [AW-1:0]          wv_a, wn_a, wp_a, wn2_a, wp2_a;
    logic [AW-1:0]          wn_d, wp_d, wn2_d, wp2_d;

    logic [AW-1:0]          free_idx;
    logic                   free_none;
    logic                   is_dump_last;

    always_comb
    begin
        free_idx  = '0;
        free_none = 1'b1;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx  = AW'(i);
                free_none = 1'b0;
            end
        end
    end

    function automatic logic [31:0] sx(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[31:0];
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] tr(input logic [31:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[VALUE_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wv_en) val_mem[wv_a] <= nv_reg;
        if (wn_en) nxt_mem[wn_a] <= wn_d;
        if (wp_en) prv_mem[wp_a] <= wp_d;
        if (wn2_en) nxt_mem[wn2_a] <= wn2_d;
        if (wp2_en) prv_mem[wp2_a] <= wp2_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            len_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        nv_reg   <= nv_next;
        key_reg  <= key_next;
        ptr_reg  <= ptr_next;
        cnt_reg  <= cnt_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;
    assign is_dump_last = (CW'(cnt_reg + 1'b1) == len_reg);

    always_comb
    begin
        logic [AW-1:0] t, a, b;
        state_next = state_reg;
        used_next  = used_reg;
        head_next  = head_reg;
        len_next   = len_reg;
        op_next    = op_reg;
        nv_next    = nv_reg;
        key_next   = key_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && out_stall;
        wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0; wn2_en = 1'b0; wp2_en = 1'b0;
        wv_a = slot_reg; wn_a = '0; wp_a = '0; wn2_a = '0; wp2_a = '0;
        wn_d = '0; wp_d = '0; wn2_d = '0; wp2_d = '0;
        t = '0; a = '0; b = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    op_next   = op_t'(in_data.operation);
                    nv_next   = tr(in_data.new_value);
                    key_next  = tr(in_data.key_value);
                    ptr_next  = head_reg;
                    cnt_next  = '0;
                    slot_next = free_idx;
                    res_next  = '{status: ST_OK, item_value: '0,
                                  node_count: 5'(len_reg), last: 1'b1};
                    state_next = S_OUT;
                    case (in_data.operation)
                        OP_INS_FRONT, OP_INS_BACK:
                        begin
                            if (free_none) res_next.status = ST_FULL;
                            else state_next = S_LINK;
                        end
                        OP_INS_AFTER, OP_INS_BEFORE:
                        begin
                            if (len_reg == '0) res_next.status = ST_EMPTY;
                            else if (free_none) res_next.status = ST_FULL;
                            else state_next = S_SEARCH;
                        end
                        OP_DEL_FRONT:
                        begin
                            if (len_reg == '0) res_next.status = ST_EMPTY;
                            else state_next = S_UNLINK;
                        end
                        OP_DEL_BACK:
                        begin
                            if (len_reg == '0) res_next.status = ST_EMPTY;
                            else
                            begin
                                ptr_next   = prv_mem[head_reg];
                                state_next = S_UNLINK;
                            end
                        end
                        OP_DEL_MATCH, OP_DEL_AFTER, OP_DEL_BEFORE:
                        begin
                            if (len_reg == '0) res_next.status = ST_EMPTY;
                            else state_next = S_SEARCH;
                        end
                        OP_DUMP:
                        begin
                            if (len_reg == '0) res_next.status = ST_EMPTY;
                            else state_next = S_DUMP;
                        end
                        default: ;
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (cnt_reg == len_reg)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else if (val_mem[ptr_reg] == key_reg)
                begin
                    case (op_reg)
                        OP_INS_AFTER, OP_INS_BEFORE, OP_DEL_MATCH:
                            state_next = (op_reg == OP_DEL_MATCH) ? S_UNLINK : S_LINK;
                        default:
                        begin
                            if (len_reg == CW'(1))
                            begin
                                res_next.status = ST_NONEIGHBOR;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ptr_next = (op_reg == OP_DEL_AFTER) ? nxt_mem[ptr_reg]
                                                                    : prv_mem[ptr_reg];
                                state_next = S_UNLINK;
                            end
                        end
                    endcase
                end
                else
                begin
                    ptr_next = nxt_mem[ptr_reg];
                    cnt_next = CW'(cnt_reg + 1'b1);
                end
            end

            S_LINK:
            begin
                // new node goes between a and b
                if (op_reg == OP_INS_AFTER)
                begin
                    a = ptr_reg; b = nxt_mem[ptr_reg];
                end
                else if (op_reg == OP_INS_BEFORE)
                begin
                    a = prv_mem[ptr_reg]; b = ptr_reg;
                end
                else
                begin
                    a = prv_mem[head_reg]; b = head_reg;
                end
                wv_en = 1'b1;
                used_next = used_reg | (CAPACITY'(1) << slot_reg);
                len_next  = CW'(len_reg + 1'b1);
                wn_en = 1'b1; wn_a = slot_reg;
                wp_en = 1'b1; wp_a = slot_reg;
                if (len_reg == '0)
                begin
                    wn_d = slot_reg; wp_d = slot_reg;
                    head_next = slot_reg;
                end
                else
                begin
                    wn_d = b; wp_d = a;
                    wn2_en = 1'b1; wn2_a = a; wn2_d = slot_reg;
                    wp2_en = 1'b1; wp2_a = b; wp2_d = slot_reg;
                    if (op_reg == OP_INS_FRONT ||
                        (op_reg == OP_INS_BEFORE && ptr_reg == head_reg))
                        head_next = slot_reg;
                end
                res_next.node_count = 5'(CW'(len_reg + 1'b1));
                state_next = S_OUT;
            end

            S_UNLINK:
            begin
                t = ptr_reg;
                a = prv_mem[t];
                b = nxt_mem[t];
                res_next.item_value = sx(val_mem[t]);
                used_next = used_reg & ~(CAPACITY'(1) << t);
                if (len_reg <= CW'(1))
                begin
                    len_next  = '0;
                    head_next = '0;
                end
                else
                begin
                    wn2_en = 1'b1; wn2_a = a; wn2_d = b;
                    wp2_en = 1'b1; wp2_a = b; wp2_d = a;
                    if (t == head_reg) head_next = b;
                    len_next = CW'(len_reg - 1'b1);
                end
                res_next.node_count = 5'((len_reg <= CW'(1)) ? '0 : CW'(len_reg - 1'b1));
                state_next = S_OUT;
            end

            S_DUMP:
            begin
                if (!ov_reg || !out_stall)
                begin
                    res_next = '{status: ST_OK, item_value: sx(val_mem[ptr_reg]),
                                 node_count: 5'(len_reg), last: is_dump_last};
                    ov_next  = 1'b1;
                    ptr_next = nxt_mem[ptr_reg];
                    cnt_next = CW'(cnt_reg + 1'b1);
                    if (is_dump_last) state_next = S_IDLE;
                end
            end

            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== tb/sv/circular_doubly_linked_list_engine_top_tb.sv =====
// Self-checking testbench for the circular doubly linked list engine.
// Depends on cdll_pkg and circular_doubly_linked_list_engine_top.
// A shadow list predicts every result; a monitor compares results in order.
module circular_doubly_linked_list_engine_top_tb;
    import cdll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL = 16;
    localparam int QUIET_LIMIT = 20000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    request_t in_data;
    logic     out_valid;
    logic     out_stall;
    result_t  out_data;

    circular_doubly_linked_list_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Shadow of the node pool
    logic signed [31:0] shadow_val [POOL];
    logic [3:0]         shadow_next [POOL];
    logic [3:0]         shadow_prev [POOL];
    logic [POOL-1:0]    shadow_used;
    logic [3:0]         shadow_head;
    int                 shadow_len;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       mismatches;
    int       results_seen;
    int       requests_sent;
    int       quiet_cycles;
    bit       hold_sender;
    bit       in_taken;
    int       op_hits [16];

    task automatic report(input string what);
    begin
        $display("mismatch @%0t: %s", $realtime, what);
        mismatches++;
    end
    endtask

    function automatic result_t make_result(logic [2:0] st, logic signed [31:0] v, bit lst);
        result_t r;
        r.status = st;
        r.item_value = v;
        r.node_count = shadow_len[4:0];
        r.last = lst;
        return r;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < POOL; i++)
            if (!shadow_used[i]) return i;
        return -1;
    endfunction

    function automatic int search_key(logic signed [31:0] key);
        logic [3:0] p;
        p = shadow_head;
        for (int n = 0; n < shadow_len; n++)
        begin
            if (shadow_val[p] == key) return p;
            p = shadow_next[p];
        end
        return -1;
    endfunction

    function automatic void link_in(int s, logic signed [31:0] v, logic [3:0] a, logic [3:0] b);
        shadow_val[s] = v;
        shadow_next[s] = b;
        shadow_prev[s] = a;
        shadow_next[a] = 4'(s);
        shadow_prev[b] = 4'(s);
        shadow_used[s] = 1'b1;
        shadow_len++;
    endfunction

    function automatic logic signed [31:0] unlink(logic [3:0] s);
        logic signed [31:0] v;
        v = shadow_val[s];
        shadow_used[s] = 1'b0;
        if (shadow_len <= 1)
        begin
            shadow_len = 0;
            shadow_head = '0;
            return v;
        end
        shadow_next[shadow_prev[s]] = shadow_next[s];
        shadow_prev[shadow_next[s]] = shadow_prev[s];
        if (s == shadow_head) shadow_head = shadow_next[s];
        shadow_len--;
        return v;
    endfunction

    // Apply one request to the shadow list and queue what the engine should return
    function automatic void predict_list_op(request_t rq);
        int s;
        int p;
        logic [3:0] t;
        logic signed [31:0] v;
        case (rq.operation)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                s = free_slot();
                if (s < 0)
                    expected_results.push_back(make_result(ST_FULL, 0, 1));
                else
                begin
                    if (shadow_len == 0)
                    begin
                        shadow_val[s] = rq.new_value;
                        shadow_next[s] = 4'(s);
                        shadow_prev[s] = 4'(s);
                        shadow_used[s] = 1'b1;
                        shadow_head = 4'(s);
                        shadow_len = 1;
                    end
                    else
                    begin
                        link_in(s, rq.new_value, shadow_prev[shadow_head], shadow_head);
                        if (rq.operation == OP_INS_FRONT) shadow_head = 4'(s);
                    end
                    expected_results.push_back(make_result(ST_OK, 0, 1));
                end
            end
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                s = free_slot();
                if (shadow_len == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1));
                else if (s < 0)
                    expected_results.push_back(make_result(ST_FULL, 0, 1));
                else
                begin
                    p = search_key(rq.key_value);
                    if (p < 0)
                        expected_results.push_back(make_result(ST_NOTFOUND, 0, 1));
                    else
                    begin
                        if (rq.operation == OP_INS_AFTER)
                            link_in(s, rq.new_value, 4'(p), shadow_next[p]);
                        else
                        begin
                            link_in(s, rq.new_value, shadow_prev[p], 4'(p));
                            if (p == shadow_head) shadow_head = 4'(s);
                        end
                        expected_results.push_back(make_result(ST_OK, 0, 1));
                    end
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (shadow_len == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1));
                else
                begin
                    t = (rq.operation == OP_DEL_FRONT) ? shadow_head : shadow_prev[shadow_head];
                    v = unlink(t);
                    expected_results.push_back(make_result(ST_OK, v, 1));
                end
            end
            OP_DEL_MATCH, OP_DEL_AFTER, OP_DEL_BEFORE:
            begin
                p = (shadow_len == 0) ? -1 : search_key(rq.key_value);
                if (shadow_len == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1));
                else if (p < 0)
                    expected_results.push_back(make_result(ST_NOTFOUND, 0, 1));
                else if (rq.operation != OP_DEL_MATCH && shadow_len == 1)
                    expected_results.push_back(make_result(ST_NONEIGHBOR, 0, 1));
                else
                begin
                    if (rq.operation == OP_DEL_MATCH) t = 4'(p);
                    else if (rq.operation == OP_DEL_AFTER) t = shadow_next[p];
                    else t = shadow_prev[p];
                    v = unlink(t);
                    expected_results.push_back(make_result(ST_OK, v, 1));
                end
            end
            OP_DUMP:
            begin
                if (shadow_len == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1));
                else
                begin
                    t = shadow_head;
                    for (int n = 0; n < shadow_len; n++)
                    begin
                        expected_results.push_back(make_result(ST_OK, shadow_val[t],
                                                               n + 1 == shadow_len));
                        t = shadow_next[t];
                    end
                end
            end
            default:
                // count and the unused codes 11..15
                expected_results.push_back(make_result(ST_OK, 0, 1));
        endcase
    endfunction

    // Pick a key: mostly a value that is in the list, so keyed requests hit
    function automatic logic signed [31:0] pick_key();
        logic [3:0] p;
        int hops;
        if (shadow_len == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(0, 7);
        p = shadow_head;
        hops = $urandom_range(0, shadow_len - 1);
        for (int i = 0; i < hops; i++) p = shadow_next[p];
        return shadow_val[p];
    endfunction

    // Driver: a request is offered after a random gap and held until accepted
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (in_taken)
        begin
            // accepted at the last rising edge
            if (send_gap == 0 && pending_requests.size() > 0 && !hold_sender)
            begin
                in_data <= pending_requests.pop_front();
            end
            else
                in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_requests.size() > 0 && !hold_sender)
            begin
                in_data <= pending_requests.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Prediction happens at acceptance, so the shadow list tracks the engine's order
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_list_op(in_data);
            op_hits[in_data.operation]++;
            requests_sent++;
        end
    end

    // Receiver stall and monitor
    int stall_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && $urandom_range(0, 2) == 0)
                stall_left <= $urandom_range(0, 12);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report($sformatf("unexpected result %p", out_data));
            else
            begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status)
                    report($sformatf("status %0d, want %0d", out_data.status, want.status));
                if (out_data.item_value !== want.item_value)
                    report($sformatf("item_value %0d, want %0d",
                                     out_data.item_value, want.item_value));
                if (out_data.node_count !== want.node_count)
                    report($sformatf("node_count %0d, want %0d",
                                     out_data.node_count, want.node_count));
                if (out_data.last !== want.last)
                    report($sformatf("last %0b, want %0b", out_data.last, want.last));
            end
        end
    end

    // Watchdog: counts cycles in which neither side hands anything over
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic request_t mk(op_t o, logic signed [31:0] nv, logic signed [31:0] k);
        request_t r;
        r.operation = o;
        r.new_value = nv;
        r.key_value = k;
        return r;
    endfunction

    // Random request with a sensible bias toward well-formed list activity
    function automatic request_t random_request();
        request_t r;
        int pick;
        r.new_value = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 9);
        r.key_value = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 30) r.operation = 4'($urandom_range(OP_INS_FRONT, OP_INS_BEFORE));
        else if (pick < 60) r.operation = 4'($urandom_range(OP_DEL_FRONT, OP_DEL_BEFORE));
        else if (pick < 85) r.operation = 4'($urandom_range(OP_COUNT, OP_DUMP));
        else r.operation = 4'($urandom_range(0, 15));
        return r;
    endfunction

    initial
    begin
        int burst;
        request_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        quiet_cycles = 0;
        hold_sender = 1'b0;
        shadow_used = '0;
        shadow_head = '0;
        shadow_len = 0;
        foreach (op_hits[i]) op_hits[i] = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list cases, extremes, head handling, unused codes
        pending_requests.push_back(mk(OP_DUMP, 0, 0));
        pending_requests.push_back(mk(OP_DEL_FRONT, 0, 0));
        pending_requests.push_back(mk(OP_DEL_AFTER, 0, 0));
        pending_requests.push_back(mk(OP_INS_AFTER, 1, 1));
        pending_requests.push_back(mk(OP_INS_BACK, 32'sh7fffffff, 0));
        pending_requests.push_back(mk(OP_DEL_BEFORE, 0, 32'sh7fffffff));
        pending_requests.push_back(mk(OP_INS_FRONT, 32'sh80000000, 0));
        pending_requests.push_back(mk(OP_INS_BEFORE, -1, 32'sh80000000));
        pending_requests.push_back(mk(OP_INS_AFTER, 5, 32'sh7fffffff));
        pending_requests.push_back(mk(OP_INS_AFTER, 6, 12345));
        pending_requests.push_back(mk(OP_DUMP, 0, 0));
        pending_requests.push_back(mk(OP_DEL_AFTER, 0, 5));
        pending_requests.push_back(mk(OP_DEL_BEFORE, 0, -1));
        pending_requests.push_back(mk(OP_DEL_MATCH, 0, 32'sh80000000));
        pending_requests.push_back(mk(OP_DEL_BACK, 0, 0));
        pending_requests.push_back(mk(OP_COUNT, 0, 0));
        r = mk(OP_COUNT, 0, 0);
        r.operation = 4'd15;
        pending_requests.push_back(r);
        // Fill the pool past capacity so the full case shows up
        for (int i = 0; i < 17; i++)
            pending_requests.push_back(mk(OP_INS_BACK, i, 0));
        pending_requests.push_back(mk(OP_INS_BEFORE, 99, 3));
        pending_requests.push_back(mk(OP_DUMP, 0, 0));

        // Pause the sender until everything outstanding has come back
        wait (pending_requests.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !in_valid);
        repeat ($urandom_range(0, 12)) @(posedge clk);
        @(negedge clk);
        hold_sender = 1'b0;

        // Random part: keys drawn from the live list, generated in small bursts
        for (int n = 0; n < 64; n++)
        begin
            wait (pending_requests.size() < 2);
            r = random_request();
            if (r.operation inside {OP_INS_AFTER, OP_INS_BEFORE, OP_DEL_MATCH,
                                    OP_DEL_AFTER, OP_DEL_BEFORE} && $urandom_range(0, 3) != 0)
            begin
                wait (pending_requests.size() == 0 && !in_valid && expected_results.size() == 0);
                r.key_value = pick_key();
            end
            pending_requests.push_back(r);
            @(negedge clk);
        end

        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);

        $display("covered %0d requests and %0d results; ins %0d, del %0d, dump %0d",
                 requests_sent, results_seen,
                 op_hits[OP_INS_FRONT] + op_hits[OP_INS_BACK] + op_hits[OP_INS_AFTER]
                     + op_hits[OP_INS_BEFORE],
                 op_hits[OP_DEL_FRONT] + op_hits[OP_DEL_BACK] + op_hits[OP_DEL_MATCH]
                     + op_hits[OP_DEL_AFTER] + op_hits[OP_DEL_BEFORE],
                 op_hits[OP_DUMP]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== circular_doubly_linked_list_engine_top.f =====
sv/cdll_pkg.sv
sv/circular_doubly_linked_list_engine_top.sv
tb/sv/circular_doubly_linked_list_engine_top_tb.sv
